/* design/plm_pkg.sv */
// Package for the phone line state monitor: widths, codes, register layout and defaults.
`default_nettype none
package plm_pkg;

  localparam int unsigned WindowLog2Default = 4;
  localparam int unsigned SampleW           = 8;
  localparam int unsigned CfgIdxW           = 4;
  localparam int unsigned CfgDataW          = 8;
  localparam int unsigned SwingW            = 5;
  localparam logic [SwingW-1:0] SwingMax    = 5'd31;
  localparam logic [SwingW-1:0] SwingRingUp = 5'd2;

  // Report codes; the first three double as line states.
  typedef enum logic [1:0] {
    RepOnHook  = 2'd0,
    RepNoLine  = 2'd1,
    RepOffHook = 2'd2,
    RepRing    = 2'd3
  } report_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHigh     = 4'd0,
    CfgHighPrev = 4'd1,
    CfgLow      = 4'd2,
    CfgMidLow   = 4'd3,
    CfgDead     = 4'd4,
    CfgPrevMin  = 4'd5,
    CfgRingLow  = 4'd6,
    CfgRingHigh = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] high_level;
    logic [SampleW-1:0] high_prev_level;
    logic [SampleW-1:0] low_level;
    logic [SampleW-1:0] mid_low_level;
    logic [SampleW-1:0] dead_level;
    logic [SampleW-1:0] prev_min_level;
    logic [SampleW-1:0] ring_low_level;
    logic [SampleW-1:0] ring_high_level;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    high_level:      8'd200,
    high_prev_level: 8'd180,
    low_level:       8'd40,
    mid_low_level:   8'd20,
    dead_level:      8'd3,
    prev_min_level:  8'd5,
    ring_low_level:  8'd5,
    ring_high_level: 8'd50
  };

  // Window status handed from the accumulator to the classifier.
  typedef struct packed {
    logic               last;
    logic [SampleW-1:0] average;
    logic               ring_up;
  } win_t;

endpackage
`default_nettype wire

/* design/plm_sample_if.sv */
// Channel carrying one line-voltage sample and the line detect pin level.
`default_nettype none
interface plm_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       pin_level;

  modport source (output valid, output sample, output pin_level, input ready);
  modport sink   (input valid, input sample, input pin_level, output ready);
endinterface
`default_nettype wire

/* design/plm_report_if.sv */
// Channel carrying one line state report per completed window.
`default_nettype none
interface plm_report_if;
  logic       valid;
  logic       ready;
  logic [1:0] report_code;
  logic [7:0] window_average;
  logic       ring_up;

  modport source (output valid, output report_code, output window_average,
                  output ring_up, input ready);
  modport sink   (input valid, input report_code, input window_average,
                  input ring_up, output ready);
endinterface
`default_nettype wire

/* design/plm_cfg_if.sv */
// Configuration write channel: register index and write data.
`default_nettype none
interface plm_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/phone_line_state_monitor.sv */
// Top level of the phone line state monitor: channel registers, configuration and wiring.
// The monitor takes one sample request per cycle unless a report is blocked, and issues
// one report after every 2**WindowLog2 samples (16 by default). The window accumulator
// and the classifier evaluate a sample in the input register, and the report is
// registered at the output; an unread report stalls only the sample that closes the
// next window. Configuration writes are always ready and take effect on the next edge.
`default_nettype none
module phone_line_state_monitor #(
  parameter int unsigned WindowLog2 = plm_pkg::WindowLog2Default
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  plm_sample_if.sink   in_i,
  plm_report_if.source out_o,
  plm_cfg_if.sink      cfg_i
);
  import plm_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       in_valid_q, in_valid_d;
  logic [7:0] sample_q;
  logic       pin_q;
  logic       out_valid_q, out_valid_d;
  report_e    code_q;
  logic [7:0] avg_q;
  logic       ring_up_q;
  logic       out_free, step, in_ready;
  win_t       win;
  report_e    report;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgHigh:     cfg_d.high_level      = cfg_i.data;
        CfgHighPrev: cfg_d.high_prev_level = cfg_i.data;
        CfgLow:      cfg_d.low_level       = cfg_i.data;
        CfgMidLow:   cfg_d.mid_low_level   = cfg_i.data;
        CfgDead:     cfg_d.dead_level      = cfg_i.data;
        CfgPrevMin:  cfg_d.prev_min_level  = cfg_i.data;
        CfgRingLow:  cfg_d.ring_low_level  = cfg_i.data;
        CfgRingHigh: cfg_d.ring_high_level = cfg_i.data;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // Only the window-closing sample needs room in the output register.
  assign out_free = !out_valid_q || out_o.ready;
  assign step     = in_valid_q && (!win.last || out_free);
  assign in_ready = !in_valid_q || step;
  assign in_i.ready = in_ready;

  assign in_valid_d  = (in_i.valid && in_ready) ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = (step && win.last) ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  plm_window #(
    .WindowLog2(WindowLog2)
  ) u_window (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .sample_i          (sample_q),
    .ring_low_level_i  (cfg_q.ring_low_level),
    .ring_high_level_i (cfg_q.ring_high_level),
    .win_o             (win)
  );

  plm_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .win_i       (win),
    .pin_level_i (pin_q),
    .cfg_i       (cfg_q),
    .report_o    (report)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      sample_q <= in_i.sample;
      pin_q    <= in_i.pin_level;
    end
    if (step && win.last) begin
      code_q    <= report;
      avg_q     <= win.average;
      ring_up_q <= win.ring_up;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.report_code    = code_q;
  assign out_o.window_average = avg_q;
  assign out_o.ring_up        = ring_up_q;

  // A sample that does not close a window never waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !win.last) |-> step)
    else $error("mid-window sample stalled");

  // A new report appears only after the window-closing sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && win.last))
    else $error("report issued outside a window end");

  // Back-pressure on the input only comes from a blocked report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_valid_q && win.last && out_valid_q && !out_o.ready))
    else $error("input stalled without a blocked report");

endmodule
`default_nettype wire

/* design/plm_window.sv */
// Window accumulator: running sum, sample count and ring-up swing counter.
`default_nettype none
module plm_window #(
  parameter int unsigned WindowLog2 = plm_pkg::WindowLog2Default
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         step_i,
  input  wire logic [7:0]   sample_i,
  input  wire logic [7:0]   ring_low_level_i,
  input  wire logic [7:0]   ring_high_level_i,
  output plm_pkg::win_t     win_o
);
  import plm_pkg::*;

  localparam int unsigned SumW = WindowLog2 + SampleW;

  logic [SumW-1:0]       sum_q, sum_d, sum_new;
  logic [WindowLog2-1:0] count_q, count_d;
  logic                  low_seen_q, low_seen_d, low_new;
  logic [SwingW-1:0]     swing_q, swing_d, swing_new;

  always_comb begin
    low_new   = low_seen_q;
    swing_new = swing_q;
    if (sample_i < ring_low_level_i) begin
      low_new = 1'b1;
    end else if (low_seen_q && (sample_i > ring_high_level_i)) begin
      if (swing_q < SwingMax) begin
        swing_new = swing_q + 1'b1;
      end
      low_new = 1'b0;
    end
    sum_new = sum_q + {{WindowLog2{1'b0}}, sample_i};
  end

  assign win_o.last    = (count_q == {WindowLog2{1'b1}});
  assign win_o.average = sum_new[SumW-1:WindowLog2];
  assign win_o.ring_up = (swing_new >= SwingRingUp);

  always_comb begin
    sum_d      = sum_q;
    count_d    = count_q;
    low_seen_d = low_seen_q;
    swing_d    = swing_q;
    if (step_i) begin
      if (win_o.last) begin
        sum_d      = '0;
        count_d    = '0;
        low_seen_d = 1'b0;
        swing_d    = '0;
      end else begin
        sum_d      = sum_new;
        count_d    = count_q + 1'b1;
        low_seen_d = low_new;
        swing_d    = swing_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      count_q    <= '0;
      low_seen_q <= 1'b0;
      swing_q    <= '0;
    end else begin
      sum_q      <= sum_d;
      count_q    <= count_d;
      low_seen_q <= low_seen_d;
      swing_q    <= swing_d;
    end
  end

endmodule
`default_nettype wire

/* design/plm_classify.sv */
// Line state classifier: decides the report at each window end.
`default_nettype none
module plm_classify (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire plm_pkg::win_t win_i,
  input  wire logic        pin_level_i,
  input  wire plm_pkg::cfg_t cfg_i,
  output plm_pkg::report_e report_o
);
  import plm_pkg::*;

  report_e      state_q, state_d, prev_state_q, prev_state_d;
  logic [7:0]   prev_avg_q, prev_avg_d;
  logic         ring_q, ring_d;
  logic         ring_mark;
  logic [7:0]   avg;

  assign avg = win_i.average;

  always_comb begin
    state_d      = state_q;
    prev_state_d = prev_state_q;
    prev_avg_d   = prev_avg_q;
    ring_d       = ring_q;
    // A jump between the high and low bands from one window to the next is a ring.
    ring_mark = ring_q ||
                ((prev_avg_q > cfg_i.high_level) && (avg < cfg_i.low_level)) ||
                ((prev_avg_q < cfg_i.low_level) && (avg > cfg_i.high_level));
    if (pin_level_i) begin
      if ((avg > cfg_i.high_level) && (prev_avg_q > cfg_i.high_prev_level)) begin
        state_d = RepOnHook;
      end else if (avg < cfg_i.dead_level) begin
        if ((prev_state_q != RepOnHook) && (prev_state_q != RepOffHook)) begin
          state_d = RepNoLine;
        end else begin
          ring_mark = 1'b1;
        end
      end else if ((avg > cfg_i.mid_low_level) && (avg < cfg_i.low_level) &&
                   (prev_avg_q > cfg_i.prev_min_level)) begin
        state_d = RepOffHook;
      end
      prev_avg_d = avg;
    end else begin
      ring_mark = 1'b1;
    end

    if (ring_mark) begin
      report_o = RepRing;
      ring_d   = !pin_level_i;
    end else begin
      report_o     = state_d;
      prev_state_d = state_d;
      ring_d       = 1'b0;
    end

    if (!(step_i && win_i.last)) begin
      state_d      = state_q;
      prev_state_d = prev_state_q;
      prev_avg_d   = prev_avg_q;
      ring_d       = ring_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= RepNoLine;
      prev_state_q <= RepNoLine;
      prev_avg_q   <= '0;
      ring_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_state_q <= prev_state_d;
      prev_avg_q   <= prev_avg_d;
      ring_q       <= ring_d;
    end
  end

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the phone line state monitor with random traffic and idling.
module tb;
  import plm_pkg::*;

  localparam int unsigned WinLog2      = WindowLog2Default;
  localparam int unsigned WinLen       = 1 << WinLog2;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned WinsPerPhase = 17;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 1000000;

  typedef enum int {IdleNone, IdleLight, IdleHeavy} idle_e;
  typedef enum int {WinHigh, WinBand, WinDead, WinLevel, WinRing, WinNoise} win_kind_e;

  typedef struct {
    logic [SampleW-1:0] sample;
    logic               pin;
    bit                 drain;
  } sample_req_t;

  typedef struct {
    report_e            code;
    logic [SampleW-1:0] avg;
    logic               ring_up;
  } report_t;

  logic clk_i;
  logic rst_ni;

  plm_sample_if in_if ();
  plm_report_if out_if ();
  plm_cfg_if    cfg_if ();

  phone_line_state_monitor u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Line state tracker, mirrors what the block should hold.
  cfg_t                       lvl;
  logic [WinLog2+SampleW-1:0] win_sum;
  int unsigned                win_cnt;
  logic                       low_seen;
  logic [SwingW-1:0]          swings;
  report_e                    line_st;
  report_e                    prev_line_st;
  logic [SampleW-1:0]         prev_avg;
  logic                       ring_mark;

  sample_req_t sample_q[$];
  report_t     exp_reports[$];
  sample_req_t cur_req;
  int unsigned gen_pos;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int          in_gap;
  int          out_stall;
  idle_e       in_mode;
  idle_e       out_mode;
  logic        in_taken;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int idle_gap(idle_e mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      IdleLight: begin
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
      end
      IdleHeavy: begin
        if (r < 30) return 0;
        if (r < 60) return $urandom_range(3, 1);
        if (r < 90) return $urandom_range(15, 4);
        return $urandom_range(80, 20);
      end
      default: return 0;
    endcase
  endfunction

  function automatic void predict_report(logic [SampleW-1:0] s, logic pin);
    logic [SampleW-1:0] avg;
    logic [SampleW-1:0] prev;
    logic               rup;
    report_t            rep;
    if (s < lvl.ring_low_level) begin
      low_seen = 1'b1;
    end else if (low_seen && s > lvl.ring_high_level) begin
      if (swings != SwingMax) swings = swings + 1'b1;
      low_seen = 1'b0;
    end
    win_sum = win_sum + s;
    win_cnt = win_cnt + 1;
    if (win_cnt != WinLen) return;

    avg      = win_sum[WinLog2 +: SampleW];
    rup      = (swings >= SwingRingUp);
    win_sum  = '0;
    win_cnt  = 0;
    low_seen = 1'b0;
    swings   = '0;

    // A jump between the high and low bands from one window to the next is a ring.
    prev = prev_avg;
    if ((prev > lvl.high_level && avg < lvl.low_level) ||
        (prev < lvl.low_level && avg > lvl.high_level)) ring_mark = 1'b1;

    if (pin) begin
      if (avg > lvl.high_level && prev > lvl.high_prev_level) begin
        line_st = RepOnHook;
      end else if (avg < lvl.dead_level) begin
        if (prev_line_st != RepOnHook && prev_line_st != RepOffHook) line_st = RepNoLine;
        else ring_mark = 1'b1;
      end else if (avg > lvl.mid_low_level && avg < lvl.low_level &&
                   prev > lvl.prev_min_level) begin
        line_st = RepOffHook;
      end
      prev_avg = avg;
    end else begin
      ring_mark = 1'b1;
    end

    if (ring_mark) begin
      rep.code = RepRing;
      if (pin) ring_mark = 1'b0;
    end else begin
      rep.code     = line_st;
      prev_line_st = line_st;
    end
    rep.avg     = avg;
    rep.ring_up = rup;
    exp_reports.push_back(rep);
  endfunction

  function automatic int pick(int lo, int hi);
    if (lo > hi) return $urandom_range(255);
    return $urandom_range(hi, lo);
  endfunction

  function automatic int clamp8(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  task automatic push_sample(int s, logic pin, bit drain);
    sample_req_t r;
    r.sample = SampleW'(s);
    r.pin    = pin;
    r.drain  = drain;
    sample_q.push_back(r);
    gen_pos = (gen_pos + 1) % WinLen;
  endtask

  // Fills up the current window; the pin mostly reads high on the closing sample.
  task automatic queue_window(win_kind_e kind, bit drain);
    int   lvl_t;
    int   v;
    int   n;
    logic pin;
    case (kind)
      WinHigh:  lvl_t = pick(int'(lvl.high_level) + 1, 255);
      WinBand:  lvl_t = pick(int'(lvl.mid_low_level) + 1, int'(lvl.low_level) - 1);
      WinDead:  lvl_t = pick(0, int'(lvl.dead_level) - 1);
      default:  lvl_t = $urandom_range(255);
    endcase
    n = 0;
    do begin
      case (kind)
        WinRing: v = (n % 2 == 0) ? pick(0, int'(lvl.ring_low_level) - 1)
                                  : pick(int'(lvl.ring_high_level) + 1, 255);
        WinNoise: v = $urandom_range(255);
        default: v = clamp8(lvl_t + int'($urandom_range(4)) - 2);
      endcase
      if (gen_pos == WinLen - 1) pin = ($urandom_range(99) < 85);
      else pin = $urandom_range(1);
      push_sample(v, pin, drain && n == 0);
      n++;
    end while (gen_pos != 0);
  endtask

  task automatic queue_phase(bit drain_first);
    win_kind_e kind;
    kind = win_kind_e'($urandom_range(WinNoise));
    for (int w = 0; w < WinsPerPhase; w++) begin
      if ($urandom_range(99) >= 55) kind = win_kind_e'($urandom_range(WinNoise));
      queue_window(kind, (drain_first && w == 0) || $urandom_range(99) < 3);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
  endtask

  task automatic write_levels(cfg_t c);
    if ($urandom_range(1)) write_reg(CfgIdxW'(NumRegs + $urandom_range(NumRegs - 1)),
                                     CfgDataW'($urandom));
    write_reg(CfgHigh, c.high_level);
    write_reg(CfgHighPrev, c.high_prev_level);
    write_reg(CfgLow, c.low_level);
    write_reg(CfgMidLow, c.mid_low_level);
    write_reg(CfgDead, c.dead_level);
    write_reg(CfgPrevMin, c.prev_min_level);
    write_reg(CfgRingLow, c.ring_low_level);
    write_reg(CfgRingHigh, c.ring_high_level);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Returns once every request is taken, every report is in and the pipeline has drained.
  task automatic wait_idle();
    while (sample_q.size() != 0 || in_if.valid || exp_reports.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sample driver.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_if.valid && !in_taken)) begin
      if (in_gap != 0) begin
        in_gap      <= in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() != 0 && !(sample_q[0].drain && exp_reports.size() != 0)) begin
        cur_req         = sample_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.sample    <= cur_req.sample;
        in_if.pin_level <= cur_req.pin;
        in_gap          <= idle_gap(in_mode);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Report backpressure.
  always @(negedge clk_i) begin
    if (out_stall != 0) begin
      out_if.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(3) == 0) out_stall <= idle_gap(out_mode);
    end
  end

  // Monitor: tracks configuration and sample requests, checks reports.
  always @(posedge clk_i) begin
    report_t want;
    in_taken <= in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CfgHigh:     lvl.high_level      = cfg_if.data;
          CfgHighPrev: lvl.high_prev_level = cfg_if.data;
          CfgLow:      lvl.low_level       = cfg_if.data;
          CfgMidLow:   lvl.mid_low_level   = cfg_if.data;
          CfgDead:     lvl.dead_level      = cfg_if.data;
          CfgPrevMin:  lvl.prev_min_level  = cfg_if.data;
          CfgRingLow:  lvl.ring_low_level  = cfg_if.data;
          CfgRingHigh: lvl.ring_high_level = cfg_if.data;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (exp_reports.size() == 0) begin
          flag_mismatch($sformatf("report with none pending: code %0d avg %0d ring_up %0b",
                                  out_if.report_code, out_if.window_average, out_if.ring_up));
        end else begin
          want = exp_reports.pop_front();
          if (out_if.report_code !== want.code)
            flag_mismatch($sformatf("report_code %0d, expected %0d",
                                    out_if.report_code, want.code));
          if (out_if.window_average !== want.avg)
            flag_mismatch($sformatf("window_average %0d, expected %0d",
                                    out_if.window_average, want.avg));
          if (out_if.ring_up !== want.ring_up)
            flag_mismatch($sformatf("ring_up %0b, expected %0b", out_if.ring_up, want.ring_up));
        end
      end
      if (in_if.valid && in_if.ready) predict_report(in_if.sample, in_if.pin_level);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("phone_line_state_monitor test failed");
    $finish;
  end

  initial begin
    cfg_t c;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample    = '0;
    in_if.pin_level = 1'b0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    in_taken        = 1'b0;
    in_gap          = 0;
    out_stall       = 0;
    in_mode         = IdleLight;
    out_mode        = IdleLight;
    gen_pos         = 0;
    err_cnt         = 0;
    lvl             = CfgReset;
    win_sum         = '0;
    win_cnt         = 0;
    low_seen        = 1'b0;
    swings          = '0;
    line_st         = RepNoLine;
    prev_line_st    = RepNoLine;
    prev_avg        = '0;
    ring_mark       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Alternating rail samples give eight ring-up swings; the low pin forces ringing.
    for (int i = 0; i < WinLen; i++)
      push_sample((i % 2 == 0) ? 0 : 255, (i == WinLen - 1) ? 1'b0 : i[1], 1'b0);
    // Full-scale window right after a ringing one, closed by the random part.
    for (int i = 0; i < WinLen / 2; i++) push_sample(255, 1'b1, 1'b0);
    queue_phase(1'b0);
    wait_idle();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: c = cfg_t'({$urandom, $urandom});
        2: c = '0;
        3: c = '1;
        4: c = CfgReset;
        5: begin
          c = cfg_t'({$urandom, $urandom});
          for (int b = 0; b < NumRegs; b++)
            if ($urandom_range(2) != 0) c[SampleW*b +: SampleW] = $urandom_range(1) ? '1 : '0;
        end
        default: c = cfg_t'({$urandom, $urandom});
      endcase
      write_levels(c);
      case (ph)
        1: begin in_mode = IdleLight; out_mode = IdleHeavy; end
        2: begin in_mode = IdleHeavy; out_mode = IdleLight; end
        4: begin in_mode = IdleNone;  out_mode = IdleNone;  end
        5: begin in_mode = IdleHeavy; out_mode = IdleHeavy; end
        6: begin in_mode = IdleLight; out_mode = IdleNone;  end
        default: begin in_mode = IdleLight; out_mode = IdleLight; end
      endcase
      queue_phase(ph == 1);
      wait_idle();
    end

    if (exp_reports.size() != 0)
      flag_mismatch($sformatf("%0d reports never arrived", exp_reports.size()));
    if (err_cnt == 0) begin
      $display("phone_line_state_monitor test passed");
    end else begin
      $display("phone_line_state_monitor test failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/plm_pkg.sv
design/plm_sample_if.sv
design/plm_report_if.sv
design/plm_cfg_if.sv
design/plm_window.sv
design/plm_classify.sv
design/phone_line_state_monitor.sv
tb/tb.sv
